// ===== sv/time_ordered_event_queue_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TIME_ORDERED_EVENT_QUEUE_UNIT_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TOEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/toeq_pkg.sv =====
`timescale 1ns / 1ps

package toeq_pkg;

    localparam int EVENT_BITS = 4;
    localparam int AGENT_BITS = 8;
    localparam int SEC_BITS   = 32;
    localparam int NSEC_BITS  = 30;
    localparam int FILL_BITS  = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED     = 2'd0,
        ST_POPPED       = 2'd1,
        ST_POP_EMPTY    = 2'd2,
        ST_DROPPED_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic                  req_type;
        logic [EVENT_BITS-1:0] event_code;
        logic [AGENT_BITS-1:0] source_id;
        logic [SEC_BITS-1:0]   time_sec;
        logic [NSEC_BITS-1:0]  time_nsec;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [EVENT_BITS-1:0] out_event_code;
        logic [AGENT_BITS-1:0] out_source_id;
        logic [SEC_BITS-1:0]   out_time_sec;
        logic [NSEC_BITS-1:0]  out_time_nsec;
        logic [FILL_BITS-1:0]  fill_level;
    } t_result;

    // one stored event
    typedef struct packed {
        logic [EVENT_BITS-1:0] ev;
        logic [AGENT_BITS-1:0] agent;
        logic [SEC_BITS-1:0]   sec;
        logic [NSEC_BITS-1:0]  nsec;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== sv/toeq_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted chain. Flags whether the new event belongs here or
// further up, and shifts with its neighbors on insert and pop.
module toeq_cell (
    input  logic               i_clk,
    input  toeq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  toeq_pkg::t_entry   i_new,
    input  toeq_pkg::t_entry   i_left,
    input  logic               i_left_take,
    input  toeq_pkg::t_entry   i_right,
    output toeq_pkg::t_entry   o_entry,
    output logic               o_take
);

    toeq_pkg::t_entry r_entry;
    logic             w_later;

    // stored time strictly later than the new one: new goes in front
    assign w_later = (r_entry.sec > i_new.sec) ||
                     ((r_entry.sec == i_new.sec) && (r_entry.nsec > i_new.nsec));
    // an empty slot always takes, so inserts land at the tail when nothing is later
    assign o_take  = !i_occupied || w_later;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (o_take && !i_left_take) begin
                r_entry <= i_new;
            end else if (o_take) begin
                r_entry <= i_left;
            end
        end else if (i_ctl.pop) begin
            r_entry <= i_right;
        end
    end

endmodule

// ===== sv/time_ordered_event_queue_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                    | Direction | Transfer
// ----------+--------------------------+-----------+---------------------------
// request   | i_start, o_busy, i_req   | in        | i_start && !o_busy at edge
// result    | o_done, o_result         | out       | o_done high for one cycle
//
// One transaction per cycle: every cell compares its stored time against the
// incoming one in parallel, so o_busy stays low and the chain shifts in the
// cycle of acceptance. o_result and o_done are registered and appear in the
// cycle after the accepting edge. Synchronous active-low reset empties the
// queue (fill count to zero); cell contents are not cleared. The receiver
// cannot stall; results are never held back.
module time_ordered_event_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  toeq_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_done,
    output toeq_pkg::t_result o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       r_count, n_count;
    logic                r_done;
    toeq_pkg::t_result   r_res, n_res;

    toeq_pkg::t_entry    w_new;
    toeq_pkg::t_entry    w_entry [DEPTH];
    logic [DEPTH-1:0]    w_take;
    toeq_pkg::t_cell_ctl w_ctl;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;

    // nothing multi-cycle inside: the chain takes a transaction every cycle
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_new.ev    = i_req.event_code;
    assign w_new.agent = i_req.source_id;
    assign w_new.sec   = i_req.time_sec;
    assign w_new.nsec  = i_req.time_nsec;

    // dropped inserts and empty pops leave the chain untouched
    assign w_ctl.ins = w_accept && (i_req.req_type == toeq_pkg::REQ_INSERT) && !w_full;
    assign w_ctl.pop = w_accept && (i_req.req_type == toeq_pkg::REQ_POP) && !w_empty;

    // head at cell 0; each cell sees its left and right neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        toeq_pkg::t_entry w_left;
        toeq_pkg::t_entry w_right;
        logic             w_left_take;

        if (g == 0) begin : g_head
            assign w_left      = w_new;
            assign w_left_take = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_take = w_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        toeq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_take (w_left_take),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
    end

    // result and count for the accepted transaction
    always_comb begin
        n_count = r_count;
        n_res   = '0;
        if (i_req.req_type == toeq_pkg::REQ_INSERT) begin
            if (w_full) begin
                n_res.status = toeq_pkg::ST_DROPPED_FULL;
            end else begin
                n_res.status = toeq_pkg::ST_INSERTED;
                n_count      = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_res.status = toeq_pkg::ST_POP_EMPTY;
            end else begin
                n_res.status         = toeq_pkg::ST_POPPED;
                n_res.out_event_code = w_entry[0].ev;
                n_res.out_source_id  = w_entry[0].agent;
                n_res.out_time_sec   = w_entry[0].sec;
                n_res.out_time_nsec  = w_entry[0].nsec;
                n_count              = r_count - CW'(1);
            end
        end
        n_res.fill_level = toeq_pkg::FILL_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== sv/toeq_checker.sv =====
`timescale 1ns / 1ps

`include "time_ordered_event_queue_unit_defines.svh"

module toeq_checker #(
    parameter int DEPTH = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input toeq_pkg::t_req    i_req,
    input logic              o_busy,
    input logic              o_done,
    input toeq_pkg::t_result o_result
);

    logic w_acc;
    logic w_no_event;

    assign w_acc      = i_start && !o_busy;
    assign w_no_event = (o_result.out_event_code == '0) && (o_result.out_source_id == '0) &&
                        (o_result.out_time_sec == '0) && (o_result.out_time_nsec == '0);

    // every accepted transaction gives a result in the next cycle
    `TOEQ_ASSERT_NEXT(a_done_after_accept, i_clk, i_rst_n, w_acc, o_done)
    // no result without a transaction
    `TOEQ_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !w_acc, !o_done)
    // only pops that succeed carry an event
    `TOEQ_ASSERT_NOW(a_fields_zero, i_clk, i_rst_n,
        o_done && (o_result.status != toeq_pkg::ST_POPPED), w_no_event)
    // a dropped insert reports a full queue
    `TOEQ_ASSERT_NOW(a_full_level, i_clk, i_rst_n,
        o_done && (o_result.status == toeq_pkg::ST_DROPPED_FULL),
        o_result.fill_level == toeq_pkg::FILL_BITS'(DEPTH))

endmodule

bind time_ordered_event_queue_unit toeq_checker #(.DEPTH(DEPTH)) u_toeq_checker (.*);
